// ----- design/ghs_pkg.sv -----
// ghs_pkg: types, codes and the section-entry function for the gzip header skipper.
// Used by ghs_step and gzip_header_skipper_unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ghs_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_PART    = 4'd5,
    PH_XLEN_LO = 4'd6,
    PH_XLEN_HI = 4'd7,
    PH_EXTRA   = 4'd8,
    PH_NAME    = 4'd9,
    PH_COMMENT = 4'd10,
    PH_CRYPT   = 4'd11,
    PH_PAYLOAD = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_LAST    = 2'd1,
    ST_PAYLOAD = 2'd2,
    ST_ERROR   = 2'd3
  } status_t;

  localparam logic [7:0]  MAGIC1      = 8'h1f;
  localparam logic [7:0]  MAGIC2      = 8'h8b;
  localparam logic [7:0]  METHOD_DEFL = 8'd8;
  localparam logic [15:0] FIXED_LEN   = 16'd6;
  localparam logic [15:0] PART_LEN    = 16'd2;
  localparam logic [15:0] CRYPT_LEN   = 16'd12;

  localparam int unsigned FLG_PART  = 1;
  localparam int unsigned FLG_EXTRA = 2;
  localparam int unsigned FLG_NAME  = 3;
  localparam int unsigned FLG_CMT   = 4;
  localparam int unsigned FLG_CRYPT = 5;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] payload_byte;
  } out_word_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  header_flags;
    logic [15:0] skip_count;
    logic        error_seen;
  } ghs_state_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] skip_count;
  } section_t;

  // First present section at or after p; absent sections fall through.
  function automatic section_t enter_section(phase_t p, logic [7:0] flags,
                                             logic [15:0] skip);
    section_t r;
    logic     at_part;
    logic     at_xlo;
    logic     at_extra;
    logic     at_name;
    logic     at_cmt;
    logic     at_crypt;
    at_part  = (p == PH_PART);
    at_xlo   = (at_part && !flags[FLG_PART]) || (p == PH_XLEN_LO);
    at_extra = (p == PH_EXTRA);
    at_name  = (at_xlo && !flags[FLG_EXTRA]) || (at_extra && skip == 16'd0) ||
               (p == PH_NAME);
    at_cmt   = (at_name && !flags[FLG_NAME]) || (p == PH_COMMENT);
    at_crypt = (at_cmt && !flags[FLG_CMT]) || (p == PH_CRYPT);
    r.skip_count = skip;
    if (p == PH_FIXED) begin
      r.phase = PH_FIXED;
      r.skip_count = FIXED_LEN;
    end else if (at_part && flags[FLG_PART]) begin
      r.phase = PH_PART;
      r.skip_count = PART_LEN;
    end else if (at_xlo && flags[FLG_EXTRA]) begin
      r.phase = PH_XLEN_LO;
    end else if (at_extra && skip != 16'd0) begin
      r.phase = PH_EXTRA;
    end else if (at_name && flags[FLG_NAME]) begin
      r.phase = PH_NAME;
    end else if (at_cmt && flags[FLG_CMT]) begin
      r.phase = PH_COMMENT;
    end else if (at_crypt && flags[FLG_CRYPT]) begin
      r.phase = PH_CRYPT;
      r.skip_count = CRYPT_LEN;
    end else begin
      r.phase = PH_PAYLOAD;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/gzip_header_skipper_unit.sv -----
// gzip_header_skipper_unit: top level of the gzip member header skipper.
// Depends on ghs_pkg and ghs_step.
//
// Usage:
//   in channel (in_valid, in_stall, in_word) carries one stream byte per word,
//   with a restart bit that starts a new header and clears a sticky error.
//   out channel (out_valid, out_stall, out_word) returns one status word per
//   input word, in order: in header, last header byte, payload (byte echoed),
//   or error.
//   out_valid rises in the cycle after input accept. Throughput: one byte
//   per cycle while no result is held; parse state and output register both
//   update in the accepting cycle, so the per-byte logic is the only loop.
//   While out_stall holds a result, in_stall is raised and the result holds.
//   Reset (rst, synchronous, active high) returns the parser to the first
//   magic byte, clears flags, count and error, and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module gzip_header_skipper_unit import ghs_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_stall,
  input  wire in_word_t in_word,
  output logic      out_valid,
  input  wire       out_stall,
  output out_word_t out_word
);

  ghs_state_t state;
  ghs_state_t state_next;
  out_word_t  res;
  logic       in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  ghs_step u_step (
    .cur  (state),
    .word (in_word),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_MAGIC1;
      state.header_flags <= 8'd0;
      state.skip_count   <= 16'd0;
      state.error_seen   <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (in_accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_word <= res;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    in_accept && state.error_seen && !in_word.restart |=> out_word.status == ST_ERROR)
    else $error("error not sticky");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_PAYLOAD |-> out_word.payload_byte == 8'd0)
    else $error("payload byte set outside payload");

  a_payload_pass: assert property (@(posedge clk) disable iff (rst)
    in_accept && state.phase == PH_PAYLOAD && !state.error_seen && !in_word.restart
    |=> out_word.status == ST_PAYLOAD && state.phase == PH_PAYLOAD)
    else $error("payload phase left without restart");

endmodule

`default_nettype wire

// ----- design/ghs_step.sv -----
// ghs_step: per-byte next-state and status logic of the gzip header skipper.
// Depends on ghs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghs_step import ghs_pkg::*; (
  input  wire ghs_state_t cur,
  input  wire in_word_t   word,
  output ghs_state_t      nxt,
  output out_word_t       res
);

  ghs_state_t s;
  section_t   sec;
  logic [7:0] b;
  logic [15:0] dec;

  assign b = word.stream_byte;

  always_comb begin
    s = cur;
    if (word.restart) begin
      s.phase        = PH_MAGIC1;
      s.header_flags = 8'd0;
      s.skip_count   = 16'd0;
      s.error_seen   = 1'b0;
    end
    nxt = s;
    res.status       = ST_HEADER;
    res.payload_byte = 8'd0;
    dec = (s.skip_count != 16'd0) ? s.skip_count - 16'd1 : s.skip_count;
    sec = '0;

    if (s.error_seen) begin
      res.status = ST_ERROR;
    end else if (s.phase >= PH_PAYLOAD) begin
      res.status       = ST_PAYLOAD;
      res.payload_byte = b;
    end else begin
      unique case (s.phase)
        PH_MAGIC1: begin
          if (b != MAGIC1) nxt.error_seen = 1'b1;
          else nxt.phase = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (b != MAGIC2) nxt.error_seen = 1'b1;
          else nxt.phase = PH_METHOD;
        end
        PH_METHOD: begin
          if (b != METHOD_DEFL) nxt.error_seen = 1'b1;
          else nxt.phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          nxt.header_flags = b;
          sec = enter_section(PH_FIXED, b, s.skip_count);
          nxt.phase = sec.phase;
          nxt.skip_count = sec.skip_count;
        end
        PH_FIXED, PH_PART, PH_EXTRA, PH_CRYPT: begin
          nxt.skip_count = dec;
          if (dec == 16'd0) begin
            if (s.phase == PH_FIXED)
              sec = enter_section(PH_PART, s.header_flags, dec);
            else if (s.phase == PH_PART)
              sec = enter_section(PH_XLEN_LO, s.header_flags, dec);
            else if (s.phase == PH_EXTRA)
              sec = enter_section(PH_NAME, s.header_flags, dec);
            else
              sec = enter_section(PH_PAYLOAD, s.header_flags, dec);
            nxt.phase = sec.phase;
            nxt.skip_count = sec.skip_count;
          end
        end
        PH_XLEN_LO: begin
          nxt.skip_count = {8'd0, b};
          nxt.phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          sec = enter_section(PH_EXTRA, s.header_flags, {b, s.skip_count[7:0]});
          nxt.phase = sec.phase;
          nxt.skip_count = sec.skip_count;
        end
        PH_NAME: begin
          if (b == 8'd0) begin
            sec = enter_section(PH_COMMENT, s.header_flags, s.skip_count);
            nxt.phase = sec.phase;
            nxt.skip_count = sec.skip_count;
          end
        end
        default: begin
          if (b == 8'd0) begin
            sec = enter_section(PH_CRYPT, s.header_flags, s.skip_count);
            nxt.phase = sec.phase;
            nxt.skip_count = sec.skip_count;
          end
        end
      endcase
      if (nxt.error_seen) res.status = ST_ERROR;
      else if (nxt.phase == PH_PAYLOAD) res.status = ST_LAST;
      else res.status = ST_HEADER;
    end
  end

endmodule

`default_nettype wire
